[rtl/vvpm_pkg.sv]
// Shared types, constants and register codes for the voice volume ramp and pan mixer.
package vvpm_pkg;

  localparam int VVPM_NUM_VOICES = 24;

  localparam int VOICE_W  = 5;
  localparam int VOL_W    = 7;
  localparam int STEP_W   = 8;
  localparam int PERIOD_W = 15;
  localparam int HWVOL_W  = 14;

  // request operations
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_BANK_MASTER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE   = 1'd1;
  localparam logic [VOL_W-1:0]     BANK_RESET      = 7'h7F;

  localparam logic [VOL_W-1:0] VOL_MAX    = 7'h7F;
  localparam logic [VOL_W-1:0] PAN_CENTER = 7'h40;

  // divide by 127*127 as a multiply by a rounded-up reciprocal and a shift
  localparam longint unsigned DIV_SQ      = 64'd16129;
  localparam int              RECIP_SHIFT = 43;
  localparam int              RECIP_W     = 30;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV_SQ - 64'd1) / DIV_SQ);

  typedef struct packed {
    logic                       operation;
    logic [VOICE_W-1:0]         voice;
    logic [VOL_W-1:0]           start_volume;
    logic [VOL_W-1:0]           target_volume;
    logic signed [STEP_W-1:0]   step;
    logic [PERIOD_W-1:0]        period;
    logic [VOL_W-1:0]           tone_master_volume;
    logic [VOL_W-1:0]           tone_volume;
    logic [VOL_W-1:0]           voice_pan;
    logic [VOL_W-1:0]           tone_master_pan;
    logic [VOL_W-1:0]           channel_pan;
  } vvpm_in_t;

  typedef struct packed {
    logic [VOICE_W-1:0] voice_out;
    logic [HWVOL_W-1:0] left_volume;
    logic [HWVOL_W-1:0] right_volume;
    logic [VOL_W-1:0]   current_volume;
    logic               ramp_done;
  } vvpm_out_t;

  // one voice entry of the state memory
  typedef struct packed {
    logic                     active;
    logic signed [STEP_W-1:0] step;
    logic [PERIOD_W-1:0]      period;
    logic [PERIOD_W-1:0]      count;
    logic [VOL_W-1:0]         level;
    logic [VOL_W-1:0]         target;
  } vvpm_ent_t;

  typedef struct packed {
    logic             go;
    logic [VOL_W-1:0] level;
    logic [VOL_W-1:0] bank;
    logic [VOL_W-1:0] tone_master;
    logic [VOL_W-1:0] tone;
    logic [VOL_W-1:0] pan0;
    logic [VOL_W-1:0] pan1;
    logic [VOL_W-1:0] pan2;
  } vvpm_mix_req_t;

  typedef struct packed {
    logic               valid;
    logic [HWVOL_W-1:0] left;
    logic [HWVOL_W-1:0] right;
  } vvpm_mix_rsp_t;

endpackage

[rtl/vvpm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module vvpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/vvpm_mix.sv]
// Volume and pan mixer: eight steps through one shared multiplier.
module vvpm_mix
  import vvpm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  vvpm_mix_req_t req,
  output vvpm_mix_rsp_t rsp
);

  localparam int ACC_W  = 29;
  localparam int PROD_W = ACC_W + RECIP_W;

  localparam logic [2:0] MS_LB    = 3'd0;
  localparam logic [2:0] MS_BASE  = 3'd1;
  localparam logic [2:0] MS_TM    = 3'd2;
  localparam logic [2:0] MS_TV    = 3'd3;
  localparam logic [2:0] MS_TONE  = 3'd4;
  localparam logic [2:0] MS_PAN0  = 3'd5;
  localparam logic [2:0] MS_PAN1  = 3'd6;
  localparam logic [2:0] MS_PAN2  = 3'd7;

  logic [2:0]         step_r;
  logic               run_r;
  logic               done_r;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [HWVOL_W-1:0] left_r, left_nxt;
  logic [HWVOL_W-1:0] right_r, right_nxt;

  logic [ACC_W-1:0]   mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [VOL_W-1:0]   pan_cur;
  logic               pan_right;

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    case (step_r)
      MS_PAN0: pan_cur = req.pan0;
      MS_PAN1: pan_cur = req.pan1;
      default: pan_cur = req.pan2;
    endcase
    pan_right = (pan_cur < PAN_CENTER);
  end

  always_comb begin
    mul_a     = acc_r;
    mul_b     = '0;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    case (step_r)
      MS_LB: begin
        mul_a   = ACC_W'(req.level);
        mul_b   = RECIP_W'(req.bank);
        acc_nxt = prod[ACC_W-1:0];
      end
      MS_BASE: begin
        // times 0x3FFF, then divide by 127*127
        mul_a   = (acc_r << HWVOL_W) - acc_r;
        mul_b   = RECIP;
        acc_nxt = ACC_W'(prod[RECIP_SHIFT +: HWVOL_W]);
      end
      MS_TM: begin
        mul_b   = RECIP_W'(req.tone_master);
        acc_nxt = prod[ACC_W-1:0];
      end
      MS_TV: begin
        mul_b   = RECIP_W'(req.tone);
        acc_nxt = prod[ACC_W-1:0];
      end
      MS_TONE: begin
        mul_b     = RECIP;
        left_nxt  = prod[RECIP_SHIFT +: HWVOL_W];
        right_nxt = prod[RECIP_SHIFT +: HWVOL_W];
      end
      default: begin
        // pan stage: below center scales right, otherwise scales left
        if (pan_right) begin
          mul_a     = ACC_W'(right_r);
          mul_b     = RECIP_W'(pan_cur);
          right_nxt = prod[6 +: HWVOL_W];
        end else begin
          mul_a    = ACC_W'(left_r);
          mul_b    = RECIP_W'(VOL_MAX - pan_cur);
          left_nxt = prod[6 +: HWVOL_W];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= MS_LB;
    end else begin
      done_r <= !req.go && run_r && (step_r == MS_PAN2);
      if (req.go) begin
        run_r  <= 1'b1;
        step_r <= MS_LB;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == MS_PAN2) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run_r) begin
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign rsp.valid = done_r;
  assign rsp.left  = left_r;
  assign rsp.right = right_r;

endmodule

[rtl/voice_volume_ramp_pan_mixer.sv]
// Top level: per-voice ramp state in RAM, read-modify-write control and output register.
//
// Requests enter on start/in_data and are taken when start is high and busy
// is low. A start request loads the voice entry in the same cycle, gives no
// result and leaves busy low. A tick request reads the voice entry, then
// either only counts the tick down (no result) or applies the step and runs
// the mixer: eight multiply steps through one shared multiplier, so a
// result appears on out_data with out_valid for one cycle after the mixer
// finishes, and the next request is taken in that same cycle. Requests for
// a voice at or above NUM_VOICES are dropped.
// Each result is shown for exactly one cycle; there is no back-pressure.
// cfg_we writes bank master volume (index 0) or mono mode (index 1) at once.
// Reset is synchronous: all voice entries read as zero through per-voice
// valid bits, bank master volume returns to 127, mono mode to 0.
module voice_volume_ramp_pan_mixer
  import vvpm_pkg::*;
#(
  parameter int NUM_VOICES = VVPM_NUM_VOICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  vvpm_in_t              in_data,
  output logic                  out_valid,
  output vvpm_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [NUM_VOICES-1:0] vld_r;
  vvpm_in_t              req_r;
  logic [AW-1:0]         addr_r;
  logic [VOL_W-1:0]      level_r;
  logic                  done_r;
  logic [VOL_W-1:0]      bank_r;
  logic                  mono_r;
  logic                  out_valid_r;
  vvpm_out_t             out_r;

  logic                  accept;
  logic                  voice_ok;
  logic                  load_wr;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  vvpm_ent_t             ram_wdata;
  logic [$bits(vvpm_ent_t)-1:0] ram_q;
  vvpm_ent_t             ent;
  vvpm_ent_t             ent_upd;
  logic                  hold;
  logic signed [9:0]     sum;
  logic signed [9:0]     tgt;
  logic [VOL_W-1:0]      level_nxt;
  logic                  done_nxt;
  vvpm_mix_req_t         mix_req;
  vvpm_mix_rsp_t         mix_rsp;
  logic [HWVOL_W-1:0]    mix_left;
  logic [HWVOL_W-1:0]    mix_right;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign voice_ok = (int'(in_data.voice) < NUM_VOICES);
  assign load_wr  = accept && voice_ok && (in_data.operation == OP_START);

  vvpm_ram #(
    .WIDTH($bits(vvpm_ent_t)),
    .DEPTH(NUM_VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (AW'(in_data.voice)),
    .rdata (ram_q)
  );

  // never-written entries read as zero
  assign ent = vld_r[addr_r] ? vvpm_ent_t'(ram_q) : '0;
  assign hold = (ent.period != '0) && (ent.count != '0);

  always_comb begin
    sum = $signed({3'b000, ent.level}) + $signed({{2{ent.step[STEP_W-1]}}, ent.step});
    tgt = $signed({3'b000, ent.target});
    level_nxt = sum[VOL_W-1:0];
    done_nxt  = 1'b0;
    if ((ent.step > 0 && sum >= tgt) || (ent.step < 0 && sum <= tgt)) begin
      level_nxt = ent.target;
      done_nxt  = 1'b1;
    end

    ent_upd = ent;
    if (hold) begin
      ent_upd.count = ent.count - PERIOD_W'(1);
    end else begin
      ent_upd.count = ent.period;
      ent_upd.level = level_nxt;
      if (done_nxt) begin
        ent_upd.active = 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = load_wr || (state_r == ST_READ);
    ram_waddr = AW'(in_data.voice);
    ram_wdata.active = 1'b1;
    ram_wdata.step   = in_data.step;
    ram_wdata.period = in_data.period;
    ram_wdata.count  = in_data.period;
    ram_wdata.level  = in_data.start_volume;
    ram_wdata.target = in_data.target_volume;
    if (state_r == ST_READ) begin
      ram_waddr = addr_r;
      ram_wdata = ent_upd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && voice_ok && in_data.operation == OP_TICK) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = hold ? ST_IDLE : ST_MIX;
      end
      ST_MIX: begin
        if (mix_rsp.valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign mix_req.go          = (state_r == ST_READ) && !hold;
  assign mix_req.level       = level_r;
  assign mix_req.bank        = bank_r;
  assign mix_req.tone_master = req_r.tone_master_volume;
  assign mix_req.tone        = req_r.tone_volume;
  assign mix_req.pan0        = req_r.voice_pan;
  assign mix_req.pan1        = req_r.tone_master_pan;
  assign mix_req.pan2        = req_r.channel_pan;

  vvpm_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mix_req),
    .rsp   (mix_rsp)
  );

  // mono: both sides take the louder one
  always_comb begin
    mix_left  = mix_rsp.left;
    mix_right = mix_rsp.right;
    if (mono_r) begin
      if (mix_rsp.right > mix_rsp.left) begin
        mix_left = mix_rsp.right;
      end else begin
        mix_right = mix_rsp.left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      bank_r      <= BANK_RESET;
      mono_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_MIX) && mix_rsp.valid;
      if (ram_we) begin
        vld_r[ram_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BANK_MASTER: bank_r <= cfg_wdata;
          REG_MONO_MODE:   mono_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_data;
      addr_r <= AW'(in_data.voice);
    end
    if (state_r == ST_READ) begin
      level_r <= level_nxt;
      done_r  <= done_nxt;
    end
    if (mix_rsp.valid) begin
      out_r.voice_out      <= req_r.voice;
      out_r.current_volume <= level_r;
      out_r.ramp_done      <= done_r;
      out_r.left_volume    <= mix_left;
      out_r.right_volume   <= mix_right;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/vvpm_chk.sv]
// Port-level checker for the voice volume ramp and pan mixer, with its bind.
module vvpm_chk
  import vvpm_pkg::*;
#(
  parameter int NUM_VOICES = VVPM_NUM_VOICES
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input vvpm_in_t              in_data,
  input logic                  out_valid,
  input vvpm_out_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a tick request for a real voice always occupies the block next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.operation == OP_TICK && int'(in_data.voice) < NUM_VOICES
    |=> busy)
    else $error("tick request did not raise busy");

  // a start request does not stall the block and produces nothing
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.operation == OP_START
    |=> !busy && !out_valid)
    else $error("start request produced a result or stalled");

  // results never come back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result is shown only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind voice_volume_ramp_pan_mixer vvpm_chk #(.NUM_VOICES(NUM_VOICES)) u_vvpm_chk (.*);

[test/vvpm_mix_checker.sv]
// Checker for the voice volume ramp and pan mixer: watches requests and results, predicts and compares.
`timescale 1ns / 1ps

module vvpm_mix_checker
  import vvpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  vvpm_in_t              in_data,
  input  logic                  out_valid,
  input  vvpm_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    mix_pending
);

  localparam longint FULL_SCALE = 64'h3FFF;
  localparam longint VOL_DIV    = 127;
  localparam longint PAN_DIV    = 64;
  localparam int     MAX_SHOWN  = 60;

  vvpm_out_t        mix_due[$];
  int               mismatches = 0;
  logic [VOL_W-1:0] bank_vol;
  logic             mono_on;

  // per-voice ramp state
  logic ramp_on     [VVPM_NUM_VOICES];
  int   ramp_inc    [VVPM_NUM_VOICES];
  int   tick_reload [VVPM_NUM_VOICES];
  int   tick_left   [VVPM_NUM_VOICES];
  int   vol_now     [VVPM_NUM_VOICES];
  int   vol_goal    [VVPM_NUM_VOICES];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < MAX_SHOWN)
      $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic predict_request(input vvpm_in_t req);
    int               v;
    int               lvl;
    logic             done;
    longint           base;
    longint           lft;
    longint           rgt;
    logic [VOL_W-1:0] pans [3];
    vvpm_out_t        res;
    v = int'(req.voice);
    if (v >= VVPM_NUM_VOICES) return;
    if (req.operation == OP_START) begin
      vol_now[v]     = int'(req.start_volume);
      vol_goal[v]    = int'(req.target_volume);
      ramp_inc[v]    = int'($signed(req.step));
      tick_reload[v] = int'(req.period);
      tick_left[v]   = int'(req.period);
      ramp_on[v]     = 1'b1;
      return;
    end
    if (tick_reload[v] != 0) begin
      // hold the step until the countdown runs out
      if (tick_left[v] > 0) begin
        tick_left[v]--;
        return;
      end
      tick_left[v] = tick_reload[v];
    end
    lvl  = vol_now[v] + ramp_inc[v];
    done = 1'b0;
    if ((ramp_inc[v] > 0 && lvl >= vol_goal[v]) || (ramp_inc[v] < 0 && lvl <= vol_goal[v])) begin
      lvl        = vol_goal[v];
      ramp_on[v] = 1'b0;
      done       = 1'b1;
    end
    vol_now[v] = lvl;
    base = longint'(lvl) * longint'(bank_vol) * FULL_SCALE / VOL_DIV / VOL_DIV;
    base = base * longint'(req.tone_master_volume) * longint'(req.tone_volume) / VOL_DIV / VOL_DIV;
    lft = base;
    rgt = base;
    pans[0] = req.voice_pan;
    pans[1] = req.tone_master_pan;
    pans[2] = req.channel_pan;
    foreach (pans[k]) begin
      if (pans[k] < PAN_CENTER)
        rgt = rgt * longint'(pans[k]) / PAN_DIV;
      else
        lft = lft * longint'(VOL_MAX - pans[k]) / PAN_DIV;
    end
    if (mono_on) begin
      if (rgt > lft) lft = rgt;
      else rgt = lft;
    end
    res.voice_out      = req.voice;
    res.left_volume    = lft[HWVOL_W-1:0];
    res.right_volume   = rgt[HWVOL_W-1:0];
    res.current_volume = lvl[VOL_W-1:0];
    res.ramp_done      = done;
    mix_due.push_back(res);
  endtask

  always @(posedge clk) begin
    vvpm_out_t want;
    if (!rst_n) begin
      mix_due.delete();
      bank_vol = BANK_RESET;
      mono_on  = 1'b0;
      for (int i = 0; i < VVPM_NUM_VOICES; i++) begin
        ramp_on[i]     = 1'b0;
        ramp_inc[i]    = 0;
        tick_reload[i] = 0;
        tick_left[i]   = 0;
        vol_now[i]     = 0;
        vol_goal[i]    = 0;
      end
    end else begin
      // results belong to earlier requests: check before taking a new one
      if (out_valid) begin
        if (mix_due.size() == 0) begin
          report_mismatch("result with none expected, voice", out_data.voice_out, -1);
        end else begin
          want = mix_due.pop_front();
          if (out_data.voice_out !== want.voice_out)
            report_mismatch("voice_out", out_data.voice_out, want.voice_out);
          if (out_data.left_volume !== want.left_volume)
            report_mismatch("left_volume", out_data.left_volume, want.left_volume);
          if (out_data.right_volume !== want.right_volume)
            report_mismatch("right_volume", out_data.right_volume, want.right_volume);
          if (out_data.current_volume !== want.current_volume)
            report_mismatch("current_volume", out_data.current_volume, want.current_volume);
          if (out_data.ramp_done !== want.ramp_done)
            report_mismatch("ramp_done", out_data.ramp_done, want.ramp_done);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_BANK_MASTER: bank_vol = cfg_wdata[VOL_W-1:0];
          REG_MONO_MODE:   mono_on  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (start && !busy) predict_request(in_data);
    end
    fail_count  <= mismatches;
    mix_pending <= mix_due.size();
  end

endmodule

[test/voice_volume_ramp_pan_mixer_tb.sv]
// Testbench top for the voice volume ramp and pan mixer: reset, stimulus and verdict.
`timescale 1ns / 1ps

module voice_volume_ramp_pan_mixer_tb;
  import vvpm_pkg::*;

  localparam int SETTLE_CYCLES = 24;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  vvpm_in_t              in_data = '0;
  logic                  out_valid;
  vvpm_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BANK_MASTER;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    mix_errors;
  int                    mix_pending;
  bit                    steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  voice_volume_ramp_pan_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  vvpm_mix_checker mix_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (mix_errors),
    .mix_pending (mix_pending)
  );

  function automatic vvpm_in_t make_req(input logic op, input int v, input int sv, input int tgt,
                                        input int stp, input int per, input int tm, input int tv,
                                        input int p0, input int p1, input int p2);
    vvpm_in_t r;
    r.operation          = op;
    r.voice              = VOICE_W'(v);
    r.start_volume       = VOL_W'(sv);
    r.target_volume      = VOL_W'(tgt);
    r.step               = STEP_W'(stp);
    r.period             = PERIOD_W'(per);
    r.tone_master_volume = VOL_W'(tm);
    r.tone_volume        = VOL_W'(tv);
    r.voice_pan          = VOL_W'(p0);
    r.tone_master_pan    = VOL_W'(p1);
    r.channel_pan        = VOL_W'(p2);
    return r;
  endfunction

  function automatic int pick_pan();
    int corners [4] = '{0, 63, 64, 127};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 3)];
    return $urandom_range(0, 127);
  endfunction

  function automatic vvpm_in_t random_req(input int v, input logic op);
    int stp;
    int per;
    int pick;
    stp = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 16) - 8 : $urandom_range(0, 254) - 127;
    pick = $urandom_range(0, 99);
    if (pick < 50)      per = 0;
    else if (pick < 90) per = $urandom_range(1, 3);
    else if (pick < 98) per = $urandom_range(4, 20);
    else                per = $urandom_range(0, 32767);
    return make_req(op, v, $urandom_range(0, 127), $urandom_range(0, 127), stp, per,
                    $urandom_range(0, 127), $urandom_range(0, 127),
                    pick_pan(), pick_pan(), pick_pan());
  endfunction

  // hold the request until taken, then, unless in steady mode, leave a random gap
  task automatic send_request(input vvpm_in_t r);
    int pick;
    int gap;
    in_data <= r;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    if (steady) return;
    pick = $urandom_range(0, 99);
    if (pick < 55)      gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else                gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every expected result is out, then let a silent tick finish
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (mix_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input int bank, input logic mono);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BANK_MASTER;
    cfg_wdata <= CFG_DATA_W'(bank);
    @(posedge clk);
    cfg_index <= REG_MONO_MODE;
    cfg_wdata <= {(CFG_DATA_W-1)'($urandom_range(0, 63)), mono};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int sent;
    int pick;
    vvpm_in_t r;
    sent = 0;
    while (sent < count) begin
      if (sent % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // out-of-range voice: dropped by the block, not counted
        r = random_req($urandom_range(VVPM_NUM_VOICES, 31), logic'($urandom_range(0, 1)));
      end else begin
        r = random_req($urandom_range(0, VVPM_NUM_VOICES - 1), (pick < 18) ? OP_START : OP_TICK);
        sent++;
      end
      send_request(r);
      if ($urandom_range(0, 199) == 0) drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // never-started voice, full ramps both ways, pan extremes
    send_request(make_req(OP_TICK, 0, 0, 0, 0, 0, 127, 127, 64, 64, 64));
    send_request(make_req(OP_START, 1, 0, 127, 127, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 1, 0, 0, 0, 0, 127, 127, 64, 64, 64));
    send_request(make_req(OP_START, 2, 127, 0, -127, 0, 127, 127, 127, 127, 127));
    send_request(make_req(OP_TICK, 2, 127, 127, 127, 32767, 127, 127, 127, 127, 127));
    send_request(make_req(OP_START, 5, 10, 120, 5, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 5, 0, 0, 0, 0, 127, 127, 0, 127, 63));
    send_request(make_req(OP_TICK, 5, 0, 0, 0, 0, 127, 127, 127, 0, 64));
    // countdown running, expiring, then reloaded
    send_request(make_req(OP_START, 3, 50, 100, 10, 2, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 3, 0, 0, 0, 0, 100, 90, 64, 64, 64));
    send_request(make_req(OP_TICK, 3, 0, 0, 0, 0, 100, 90, 64, 64, 64));
    send_request(make_req(OP_TICK, 3, 0, 0, 0, 0, 100, 90, 64, 64, 64));
    send_request(make_req(OP_TICK, 3, 0, 0, 0, 0, 100, 90, 64, 64, 64));
    // zero step never completes
    send_request(make_req(OP_START, 4, 64, 64, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 4, 0, 0, 0, 0, 127, 127, 30, 100, 64));
    // voices past the last one are dropped
    send_request(make_req(OP_START, 24, 127, 127, 127, 0, 127, 127, 127, 127, 127));
    send_request(make_req(OP_TICK, 31, 127, 127, -1, 32767, 127, 127, 127, 127, 127));
    send_request(make_req(OP_TICK, 24, 0, 0, 0, 0, 127, 127, 64, 64, 64));
    // longest period only counts down
    send_request(make_req(OP_START, 23, 20, 127, 1, 32767, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 23, 0, 0, 0, 0, 127, 127, 64, 64, 64));
    // inactive ramp still steps and mixes
    send_request(make_req(OP_START, 6, 1, 0, -1, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 6, 0, 0, 0, 0, 127, 127, 64, 64, 64));
    send_request(make_req(OP_TICK, 6, 0, 0, 0, 0, 0, 127, 64, 64, 64));
    send_request(make_req(OP_TICK, 1, 0, 0, 0, 0, 127, 127, 64, 64, 64));

    run_random(430);
    write_settings(0, 1'b0);
    run_random(400);
    write_settings(127, 1'b1);
    send_request(make_req(OP_START, 7, 100, 127, 127, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 7, 0, 0, 0, 0, 127, 127, 0, 127, 64));
    run_random(400);
    write_settings($urandom_range(1, 126), 1'b1);
    run_random(400);
    write_settings(1, 1'b0);
    run_random(120);

    drain();
    if (mix_errors == 0 && mix_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/vvpm_pkg.sv
rtl/vvpm_ram.sv
rtl/vvpm_mix.sv
rtl/voice_volume_ramp_pan_mixer.sv
rtl/vvpm_chk.sv
test/vvpm_mix_checker.sv
test/voice_volume_ramp_pan_mixer_tb.sv
